// ===== rtl/sha256_pkg.sv =====
// Package: SHA-256 round constants, initial hash values and shared types.
`timescale 1ns / 1ps
package sha256_pkg;

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] H_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef logic [31:0] hash_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } rnd_ctl_type;

   function automatic hash_word_type rotr(hash_word_type x, int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== rtl/sha256_if.sv =====
// Interfaces: request and response valid/ready channels.
`timescale 1ns / 1ps
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;
   modport source (output valid, opcode, data_byte, input ready);
   modport sink (input valid, opcode, data_byte, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sha256_round.sv =====
// Round unit: one SHA-256 round per cycle while busy, with a rolling 16-word schedule.
`timescale 1ns / 1ps
module sha256_round
   import sha256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  rnd_ctl_type   ctl,
   input  hash_word_type blk_words [16],
   input  hash_word_type h_in [8],
   output hash_word_type v_out [8],
   output logic          done
);

   hash_word_type w_ff [16];
   hash_word_type w_in [16];
   hash_word_type v_ff [8];
   hash_word_type v_in [8];
   logic [6:0]    cnt_ff;
   logic [6:0]    cnt_in;
   hash_word_type wt;
   hash_word_type wn;
   hash_word_type t1;
   hash_word_type t2;
   hash_word_type e;
   hash_word_type a;

   always_comb begin
      wt = w_ff[0];
      wn = (rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10)) + w_ff[9]
         + (rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3)) + w_ff[0];
      e = v_ff[4];
      a = v_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v_ff[5]) ^ (~e & v_ff[6]))
         + K_TABLE[cnt_ff[5:0]] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_in = w_ff;
      v_in = v_ff;
      cnt_in = cnt_ff;
      if (ctl.start) begin
         w_in = blk_words;
         v_in = h_in;
         cnt_in = 7'd0;
      end else if (ctl.busy && !cnt_ff[6]) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
         w_in[15] = wn;
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         cnt_in = cnt_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 7'd64;
      end else begin
         cnt_ff <= cnt_in;
      end
      w_ff <= w_in;
      v_ff <= v_in;
   end

   assign v_out = v_ff;
   assign done = cnt_ff[6];

endmodule

// ===== rtl/sha256_hash_engine_core.sv =====
// Top level: SHA-256 byte-stream hash engine with sequencer and block buffer.
// Absorb: one byte per cycle while idle; the 64th byte starts a block compression
// (start, 64 rounds in the shared round unit, a done check, the chaining add).
// Finish: pads the block with zeros and the bit length (one more block if fill >= 56),
// one compression per padded block, then eight digest beats, one per cycle while rsp is ready.
// Synchronous reset loads the initial hash values and a zero bit count.
`timescale 1ns / 1ps
module sha256_hash_engine_core
   import sha256_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);

   state_type     state_ff, state_in;
   hash_word_type h_ff [8];
   hash_word_type h_in [8];
   logic [7:0]    buf_ff [64];
   logic [63:0]   cnt_ff, cnt_in;
   logic [5:0]    pos_ff, pos_in;
   logic          fin_ff, fin_in;
   logic          two_ff, two_in;
   logic [2:0]    idx_ff, idx_in;
   logic          shift_en;
   logic [7:0]    shift_byte;
   rnd_ctl_type   ctl;
   hash_word_type blk_words [16];
   hash_word_type v_out [8];
   logic          rnd_done;
   logic [5:0]    fill;
   logic [2:0]    len_sel;

   assign fill = cnt_ff[8:3];
   assign len_sel = ~pos_ff[2:0];

   // block buffer is a byte shift register: oldest byte at index 0
   always_comb begin
      for (int i = 0; i < 16; i++)
         blk_words[i] = {buf_ff[4*i], buf_ff[4*i+1], buf_ff[4*i+2], buf_ff[4*i+3]};
   end

   sha256_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .blk_words (blk_words),
      .h_in      (h_ff),
      .v_out     (v_out),
      .done      (rnd_done)
   );

   always_comb begin
      state_in = state_ff;
      h_in = h_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      fin_in = fin_ff;
      two_in = two_ff;
      idx_in = idx_ff;
      shift_en = 1'b0;
      shift_byte = 8'h00;
      ctl = '0;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               shift_en = 1'b1;
               if (req.opcode == OP_ABSORB) begin
                  shift_byte = req.data_byte;
                  cnt_in = cnt_ff + 64'd8;
                  fin_in = 1'b0;
                  if (fill == 6'd63) state_in = ST_PAD;
               end else begin
                  shift_byte = PAD_BYTE;
                  pos_in = fill + 6'd1;
                  fin_in = 1'b1;
                  two_in = (fill >= 6'd56);
                  state_in = (fill == 6'd63) ? ST_PAD : ST_FILL;
               end
            end
         end
         ST_FILL: begin
            shift_en = 1'b1;
            // length goes in the last 8 bytes of the final block, most significant first
            if (pos_ff >= 6'd56 && !two_ff) shift_byte = cnt_ff[{len_sel, 3'b000} +: 8];
            pos_in = pos_ff + 6'd1;
            if (pos_ff == 6'd63) state_in = ST_PAD;
         end
         ST_PAD: begin
            ctl.start = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            ctl.busy = 1'b1;
            if (rnd_done) state_in = ST_ADD;
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_out[i];
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (two_ff) begin
               two_in = 1'b0;
               pos_in = 6'd0;
               state_in = ST_FILL;
            end else begin
               idx_in = 3'd0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  h_in = H_INIT;
                  cnt_in = '0;
                  fin_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.digest_word = h_ff[idx_ff];
   assign rsp.word_index = idx_ff;
   assign rsp.last_word = (idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         h_ff <= H_INIT;
         cnt_ff <= '0;
         pos_ff <= '0;
         fin_ff <= 1'b0;
         two_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         h_ff <= h_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         fin_ff <= fin_in;
         two_ff <= two_in;
         idx_ff <= idx_in;
      end
      if (shift_en) begin
         for (int i = 0; i < 63; i++) buf_ff[i] <= buf_ff[i + 1];
         buf_ff[63] <= shift_byte;
      end
   end

endmodule
